/* rtl/core/dashed_line_tessellator_assert.svh */
// Assertion macros for the dashed line tessellator checker.
`ifndef DASHED_LINE_TESSELLATOR_ASSERT_SVH
`define DASHED_LINE_TESSELLATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DLT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dashed line tessellator: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define DLT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dashed line tessellator: next-cycle check failed");

`endif

/* rtl/core/dlt_pkg.sv */
// Shared types and constants of the dashed line tessellator.
package dlt_pkg;

  // Operation of the shared iterative unit
  typedef enum logic {
    OP_DIV  = 1'b0,
    OP_SQRT = 1'b1
  } iter_op_t;

  localparam int SRC_W   = 50;  // dividend / radicand width
  localparam int LEN_W   = 25;  // segment length in fine units
  localparam int REM_W   = 28;  // partial remainder width
  localparam int CNT_W   = 6;
  localparam int DIV_ITERS  = SRC_W;
  localparam int SQRT_ITERS = SRC_W / 2;

  localparam int VERTS_PER_DASH = 6;
  localparam logic [16:0] GAP_NUM = 17'd10813;

  // Register indexes
  localparam logic [7:0] REG_LINE_WIDTH = 8'd0;
  localparam logic [7:0] REG_DASH_SIZE  = 8'd1;
  localparam logic [7:0] REG_LINE_COLOR = 8'd2;

  typedef struct packed {
    logic     start;
    iter_op_t op;
  } iter_req_t;

  typedef struct packed {
    logic done;
  } iter_rsp_t;

endpackage

/* rtl/core/dlt_iter.sv */
// Shared iterative unit: restoring division or digit-by-digit square root.
module dlt_iter (
  input  logic                       clk,
  input  logic                       rst,
  input  dlt_pkg::iter_req_t         req,
  input  logic [dlt_pkg::SRC_W-1:0]  src_in,
  input  logic [dlt_pkg::LEN_W-1:0]  divisor,
  output dlt_pkg::iter_rsp_t         rsp,
  output logic [dlt_pkg::SRC_W-1:0]  res
);

  logic [dlt_pkg::SRC_W-1:0] src;
  logic [dlt_pkg::REM_W-1:0] rem;
  logic [dlt_pkg::REM_W-1:0] cand;
  logic [dlt_pkg::REM_W-1:0] trial;
  logic [dlt_pkg::CNT_W-1:0] cnt;
  dlt_pkg::iter_op_t         op;
  logic                      running;
  logic                      ge;

  // One shared compare and subtract per cycle
  always_comb begin
    if (op == dlt_pkg::OP_SQRT) begin
      cand  = {rem[dlt_pkg::REM_W-3:0], src[dlt_pkg::SRC_W-1 -: 2]};
      trial = {res[dlt_pkg::REM_W-3:0], 2'b01};
    end else begin
      cand  = {rem[dlt_pkg::REM_W-2:0], src[dlt_pkg::SRC_W-1]};
      trial = {{(dlt_pkg::REM_W-dlt_pkg::LEN_W){1'b0}}, divisor};
    end
    ge = (cand >= trial);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running  <= 1'b0;
      rsp.done <= 1'b0;
      cnt      <= '0;
      op       <= dlt_pkg::OP_DIV;
    end else begin
      rsp.done <= 1'b0;
      if (req.start) begin
        src     <= src_in;
        rem     <= '0;
        res     <= '0;
        op      <= req.op;
        running <= 1'b1;
        cnt     <= (req.op == dlt_pkg::OP_SQRT) ? dlt_pkg::CNT_W'(dlt_pkg::SQRT_ITERS)
                                                : dlt_pkg::CNT_W'(dlt_pkg::DIV_ITERS);
      end else if (running) begin
        rem <= ge ? (cand - trial) : cand;
        res <= {res[dlt_pkg::SRC_W-2:0], ge};
        src <= (op == dlt_pkg::OP_SQRT) ? {src[dlt_pkg::SRC_W-3:0], 2'b00}
                                        : {src[dlt_pkg::SRC_W-2:0], 1'b0};
        cnt <= cnt - dlt_pkg::CNT_W'(1);
        if (cnt == dlt_pkg::CNT_W'(1)) begin
          running  <= 1'b0;
          rsp.done <= 1'b1;
        end
      end
    end
  end

endmodule

/* rtl/core/dashed_line_tessellator.sv */
// Dashed line tessellator top level: sequencer, multiplier and vertex output.
//
//  channel | dir | handshake            | payload
//  s_*     | in  | s_tvalid / s_tready  | s_tdata: start_x, start_y, end_x, end_y
//  m_*     | out | m_tvalid / m_tready  | m_tdata: vertex_x, vertex_y, vertex_color; m_tlast
//  cfg_*   | in  | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// A segment with n dashes takes a 25-step square root, n + 1 count steps and
// 2 + 4*n divisions of 50 steps, each after its operand multiply; the square
// root and the divisions run in the one shared unit, the count steps in the sequencer.
// Each dash then drives its 6 vertices out at one per cycle when m_tready is high.
// s_tready is high only while the sequencer is idle; a held output stalls it.
// Reset is synchronous; it clears the sequencer and output valid, and presets the registers.
module dashed_line_tessellator #(
  parameter int MAX_DASHES = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // start_x, start_y, end_x, end_y
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // vertex_x, vertex_y, vertex_color
  output logic        m_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int NW = $clog2(MAX_DASHES + 1);
  localparam int FW = 44;

  typedef enum logic [3:0] {
    S_IDLE, S_SQX, S_SQY, S_SUM, S_SQGO, S_SQW, S_GAPM, S_PER,
    S_CNT, S_MUL, S_DIVGO, S_DIVW, S_EMIT
  } state_t;

  state_t state;

  logic [15:0] line_width;
  logic [15:0] dash_size;
  logic [31:0] line_color;

  logic signed [15:0] sx, sy;
  logic signed [16:0] dx, dy;
  logic [32:0] l2;
  logic [dlt_pkg::LEN_W-1:0] len;
  logic [23:0] dash_f;
  logic [23:0] gap;
  logic [24:0] period;
  logic [24:0] cnt_rem;
  logic [NW-1:0] n;
  logic [NW-1:0] di;
  logic [25:0] t;
  logic [2:0] k;
  logic [2:0] vi;
  logic signed [FW-1:0] px, py, ax, ay, bx, by;
  logic signed [43:0] prod;

  // Shared multiplier operands
  logic signed [16:0] mul_a;
  logic [25:0] mul_b;
  logic signed [43:0] mul_p;
  logic [16:0] adx, ady;
  logic [25:0] te;

  assign adx = dx[16] ? 17'(-dx) : 17'(dx);
  assign ady = dy[16] ? 17'(-dy) : 17'(dy);
  assign te  = t + {2'b00, dash_f};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_SQX:  begin mul_a = signed'(adx); mul_b = {9'b0, adx}; end
      S_SQY:  begin mul_a = signed'(ady); mul_b = {9'b0, ady}; end
      S_GAPM: begin mul_a = signed'(dlt_pkg::GAP_NUM); mul_b = {10'b0, dash_size}; end
      S_MUL: begin
        case (k)
          3'd0:         mul_a = dy;
          3'd1:         mul_a = dx;
          3'd2, 3'd4:   mul_a = dx;
          default:      mul_a = dy;
        endcase
        case (k)
          3'd0, 3'd1:   mul_b = {3'b0, line_width, 7'b0};
          3'd2, 3'd3:   mul_b = t;
          default:      mul_b = te;
        endcase
      end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    mul_p = mul_a * signed'({1'b0, mul_b});
  end

  // Rounded division setup: |prod|*256 + len/2
  logic [43:0] prod_mag;
  logic [dlt_pkg::SRC_W-1:0] dividend;
  logic neg_q;

  assign prod_mag = prod[43] ? 44'(-prod) : 44'(prod);
  assign dividend = {prod_mag[41:0], 8'b0}
                  + {{(dlt_pkg::SRC_W-dlt_pkg::LEN_W+1){1'b0}}, len[dlt_pkg::LEN_W-1:1]};
  assign neg_q    = prod[43] ^ (k == 3'd0);

  // Shared iterative unit
  dlt_pkg::iter_req_t req;
  dlt_pkg::iter_rsp_t rsp;
  logic [dlt_pkg::SRC_W-1:0] iter_src;
  logic [dlt_pkg::SRC_W-1:0] iter_res;

  assign req.start = (state == S_SQGO) || (state == S_DIVGO);
  assign req.op    = (state == S_SQGO) ? dlt_pkg::OP_SQRT : dlt_pkg::OP_DIV;
  assign iter_src  = (state == S_SQGO) ? {1'b0, l2, 16'b0} : dividend;

  dlt_iter u_iter (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .src_in  (iter_src),
    .divisor (len),
    .rsp     (rsp),
    .res     (iter_res)
  );

  logic signed [FW-1:0] q_val;
  logic signed [FW-1:0] q_mag;
  assign q_mag = signed'({1'b0, iter_res[FW-2:0]});
  assign q_val = neg_q ? -q_mag : q_mag;

  // Vertex selection for the quad's two triangles
  logic use_b, plus;
  logic signed [FW-1:0] fx, fy;
  assign use_b = (vi == 3'd1) || (vi == 3'd2) || (vi == 3'd4);
  assign plus  = (vi == 3'd2) || (vi == 3'd3) || (vi == 3'd4);
  assign fx = (use_b ? bx : ax) + (plus ? px : -px);
  assign fy = (use_b ? by : ay) + (plus ? py : -py);

  // Fine to signed Q16.0 with rounding away from zero and saturation
  function automatic logic [15:0] to_coord(input logic signed [FW-1:0] f);
    logic [FW-1:0] mag;
    logic [FW-1:0] r;
    mag = f[FW-1] ? FW'(-f) : FW'(f);
    r   = (mag + FW'(128)) >> 8;
    if (f[FW-1]) begin
      to_coord = (r > FW'(32768)) ? 16'h8000 : 16'(-r);
    end else begin
      to_coord = (r > FW'(32767)) ? 16'h7fff : r[15:0];
    end
  endfunction

  logic signed [FW-1:0] sx_f, sy_f;
  assign sx_f = FW'(sx) <<< 8;
  assign sy_f = FW'(sy) <<< 8;

  logic [24:0] gap_val;
  assign gap_val = 25'((prod[30:0] + 31'd32) >> 6);

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      line_width <= 16'd16;
      dash_size  <= 16'd160;
      line_color <= 32'hff000000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        dlt_pkg::REG_LINE_WIDTH: line_width <= cfg_data[15:0];
        dlt_pkg::REG_DASH_SIZE:  dash_size  <= cfg_data[15:0];
        dlt_pkg::REG_LINE_COLOR: line_color <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      m_tlast  <= 1'b0;
      k        <= '0;
      vi       <= '0;
      di       <= '0;
      n        <= '0;
    end else begin
      // Emission reloads the output register itself; elsewhere a taken vertex drops
      if (m_tready && state != S_EMIT) m_tvalid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            sx    <= signed'(s_tdata[15:0]);
            sy    <= signed'(s_tdata[31:16]);
            dx    <= 17'(signed'(s_tdata[47:32])) - 17'(signed'(s_tdata[15:0]));
            dy    <= 17'(signed'(s_tdata[63:48])) - 17'(signed'(s_tdata[31:16]));
            state <= S_SQX;
          end
        end
        S_SQX: begin
          prod  <= mul_p;
          state <= S_SQY;
        end
        S_SQY: begin
          l2    <= prod[32:0];
          prod  <= mul_p;
          state <= S_SUM;
        end
        S_SUM: begin
          l2    <= l2 + prod[32:0];
          state <= S_SQGO;
        end
        S_SQGO: state <= S_SQW;
        S_SQW: begin
          if (rsp.done) begin
            len   <= iter_res[dlt_pkg::LEN_W-1:0];
            state <= S_GAPM;
          end
        end
        S_GAPM: begin
          prod   <= mul_p;
          dash_f <= {dash_size, 8'b0};
          state  <= S_PER;
        end
        S_PER: begin
          gap     <= gap_val[23:0];
          period  <= {1'b0, dash_f} + gap_val;
          cnt_rem <= len;
          n       <= '0;
          state   <= (len == '0) ? S_IDLE : S_CNT;
        end
        S_CNT: begin
          // Dash count by repeated subtraction, saturating
          if (period == '0) begin
            state <= S_IDLE;
          end else if (n < NW'(MAX_DASHES) && cnt_rem >= period) begin
            cnt_rem <= cnt_rem - period;
            n       <= n + NW'(1);
          end else if (n == '0) begin
            state <= S_IDLE;
          end else begin
            t     <= 26'(({1'b0, cnt_rem} + {2'b0, gap}) >> 1);
            k     <= '0;
            di    <= '0;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= mul_p;
          state <= S_DIVGO;
        end
        S_DIVGO: state <= S_DIVW;
        S_DIVW: begin
          if (rsp.done) begin
            case (k)
              3'd0:    px <= q_val;
              3'd1:    py <= q_val;
              3'd2:    ax <= sx_f + q_val;
              3'd3:    ay <= sy_f + q_val;
              3'd4:    bx <= sx_f + q_val;
              default: by <= sy_f + q_val;
            endcase
            if (k == 3'd5) begin
              vi    <= '0;
              state <= S_EMIT;
            end else begin
              k     <= k + 3'd1;
              state <= S_MUL;
            end
          end
        end
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {line_color, to_coord(fy), to_coord(fx)};
            m_tlast  <= (vi == 3'(dlt_pkg::VERTS_PER_DASH - 1)) && (di + NW'(1) == n);
            if (vi == 3'(dlt_pkg::VERTS_PER_DASH - 1)) begin
              if (di + NW'(1) == n) begin
                state <= S_IDLE;
              end else begin
                di    <= di + NW'(1);
                t     <= t + {1'b0, period};
                k     <= 3'd2;
                state <= S_MUL;
              end
            end else begin
              vi <= vi + 3'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/dlt_checker.sv */
// Port-level checks of the dashed line tessellator, bound to the top level.
`include "dashed_line_tessellator_assert.svh"

module dlt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [63:0] m_tdata,
  input logic        m_tlast
);

  // A segment in flight blocks the input until its last vertex is out
  `DLT_ASSERT_NOW(a_busy_mid_run, clk, rst, m_tvalid && !m_tlast, !s_tready)

  // An accepted segment takes the input side busy the next cycle
  `DLT_ASSERT_NEXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)

  // A stalled vertex holds
  `DLT_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready,
                   m_tvalid && $stable(m_tdata) && $stable(m_tlast))

endmodule

bind dashed_line_tessellator dlt_checker u_dlt_checker (.*);

/* tb/tb_top.sv */
// Self-checking testbench for the dashed line tessellator.
module tb_top;

  localparam int MAX_DASHES = 10;
  localparam int GAP_K = 10813;
  localparam int IDLE_LIMIT = 40000;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [31:0]        color;
    logic               last;
  } vertex_t;

  // Expected vertex stream built from accepted segments
  class vertex_board;
    vertex_t pending[$];
    int      errors;
    logic [15:0] width_q;
    logic [15:0] dash_q;
    logic [31:0] color_q;

    function void set_reg(logic [7:0] idx, logic [31:0] val);
      if (idx == dlt_pkg::REG_LINE_WIDTH) width_q = val[15:0];
      else if (idx == dlt_pkg::REG_DASH_SIZE) dash_q = val[15:0];
      else if (idx == dlt_pkg::REG_LINE_COLOR) color_q = val;
    endfunction

    function longint rdiv(longint a, longint d);
      if (a >= 0) return (a + d / 2) / d;
      return -((-a + d / 2) / d);
    endfunction

    function logic [15:0] sat_coord(longint fine);
      longint v;
      v = rdiv(fine, 256);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
    endfunction

    function longint root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return longint'(r);
    endfunction

    function void note_segment(logic [63:0] seg);
      longint sx, sy, dx, dy, len, dsh, gap, per, n, off, hw, px, py;
      longint ts, te, ax, ay, bx, by;
      longint vx[6], vy[6];
      vertex_t v;
      sx = longint'($signed(seg[15:0]));
      sy = longint'($signed(seg[31:16]));
      dx = longint'($signed(seg[47:32])) - sx;
      dy = longint'($signed(seg[63:48])) - sy;
      len = root(longint'(dx * dx + dy * dy) << 16);
      dsh = longint'(dash_q) * 256;
      gap = (longint'(dash_q) * GAP_K + 32) / 64;
      per = dsh + gap;
      if (len == 0 || per == 0) return;
      n = len / per;
      if (n > MAX_DASHES) n = MAX_DASHES;
      if (n == 0) return;
      off = (len - (n * dsh + (n - 1) * gap)) / 2;
      hw = longint'(width_q) * 128;
      px = rdiv(-dy * hw * 256, len);
      py = rdiv(dx * hw * 256, len);
      for (int i = 0; i < n; i++) begin
        ts = off + i * per;
        te = ts + dsh;
        ax = sx * 256 + rdiv(dx * ts * 256, len);
        ay = sy * 256 + rdiv(dy * ts * 256, len);
        bx = sx * 256 + rdiv(dx * te * 256, len);
        by = sy * 256 + rdiv(dy * te * 256, len);
        vx[0] = ax - px; vy[0] = ay - py;
        vx[1] = bx - px; vy[1] = by - py;
        vx[2] = bx + px; vy[2] = by + py;
        vx[3] = ax + px; vy[3] = ay + py;
        vx[4] = bx + px; vy[4] = by + py;
        vx[5] = ax - px; vy[5] = ay - py;
        for (int k = 0; k < 6; k++) begin
          v.x = sat_coord(vx[k]);
          v.y = sat_coord(vy[k]);
          v.color = color_q;
          v.last = (i == n - 1) && (k == 5);
          pending.push_back(v);
        end
      end
    endfunction

    function void check_vertex(logic [63:0] d, logic lst);
      vertex_t e;
      if (pending.size() == 0) begin
        $error("unexpected vertex %h", d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[15:0] !== e.x) begin
        $error("vertex_x exp %0d got %0d", e.x, $signed(d[15:0])); errors++;
      end
      if (d[31:16] !== e.y) begin
        $error("vertex_y exp %0d got %0d", e.y, $signed(d[31:16])); errors++;
      end
      if (d[63:32] !== e.color) begin
        $error("vertex_color exp %h got %h", e.color, d[63:32]); errors++;
      end
      if (lst !== e.last) begin
        $error("last exp %0b got %0b", e.last, lst); errors++;
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        s_tvalid, s_tready;
  logic [63:0] s_tdata;
  logic        m_tvalid, m_tready;
  logic [63:0] m_tdata;
  logic        m_tlast;
  logic        cfg_valid, cfg_ready;
  logic [7:0]  cfg_index;
  logic [31:0] cfg_data;

  vertex_board board;
  int idle_cycles;
  int out_wait;
  bit sink_hold;

  dashed_line_tessellator #(.MAX_DASHES(MAX_DASHES)) u_dut (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // Send one segment with a random lead-in gap; valid stays up until the next call
  task automatic send_segment(logic [15:0] x0, y0, x1, y1);
    int lead;
    lead = $urandom_range(0, 19) * $urandom_range(0, 1);
    if (lead != 0) begin
      s_tvalid <= 0;
      repeat (lead) @(negedge clk);
    end
    s_tvalid <= 1;
    s_tdata  <= {y1, x1, y0, x0};
    do @(posedge clk); while (!s_tready);
    board.note_segment({y1, x1, y0, x0});
    @(negedge clk);
  endtask

  // Register write once the block is idle and the output stream has drained
  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    s_tvalid <= 0;
    while (board.pending.size() != 0 || !s_tready) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  task automatic random_segments(int cnt, int span);
    logic [15:0] x0, y0;
    for (int i = 0; i < cnt; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_segment(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
      end else begin
        x0 = 16'($urandom);
        y0 = 16'($urandom);
        send_segment(x0, y0, 16'(x0 + $urandom_range(0, span) - span / 2),
                     16'(y0 + $urandom_range(0, span) - span / 2));
      end
    end
  endtask

  // Output side: a random wait before each vertex is taken, with stall-free stretches
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else begin
      m_tready <= sink_hold || (out_wait == 0);
    end
  end

  // Check vertices, draw the next output wait and watch for a hang
  always @(posedge clk) begin
    if (rst) begin
      out_wait <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        board.check_vertex(m_tdata, m_tlast);
        out_wait <= $urandom_range(0, 19);
      end else if (m_tvalid && out_wait > 0) begin
        out_wait <= out_wait - 1;
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
        $display("[dashed_line_tessellator] ERROR");
        $finish;
      end
    end
  end

  initial begin
    board = new();
    board.set_reg(dlt_pkg::REG_LINE_WIDTH, 16);
    board.set_reg(dlt_pkg::REG_DASH_SIZE, 160);
    board.set_reg(dlt_pkg::REG_LINE_COLOR, 32'hFF00_0000);
    idle_cycles = 0;
    sink_hold = 0;
    rst = 1;
    s_tvalid = 0; s_tdata = 0;
    cfg_valid = 0; cfg_index = 0; cfg_data = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed: zero length, short, diagonal, saturation, corners
    send_segment(16'd100, 16'd100, 16'd100, 16'd100);
    send_segment(16'd0, 16'd0, 16'd100, 16'd0);
    send_segment(16'd0, 16'd0, 16'd1000, 16'd0);
    send_segment(16'd0, 16'd0, 16'd0, -16'sd1000);
    send_segment(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
    send_segment(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF);
    send_segment(16'h7FF0, 16'h7FF0, 16'h7000, 16'h7F00);
    write_reg(dlt_pkg::REG_LINE_WIDTH, 32'd0);
    send_segment(16'd10, 16'd20, 16'd900, 16'd700);
    write_reg(dlt_pkg::REG_LINE_WIDTH, 32'hFFFF);
    send_segment(16'h8000, 16'd0, 16'd0, 16'd0);
    write_reg(dlt_pkg::REG_DASH_SIZE, 32'd1);
    write_reg(dlt_pkg::REG_LINE_COLOR, 32'hFFFF_FFFF);
    send_segment(16'd0, 16'd0, 16'd3, 16'd4);
    send_segment(16'd0, 16'd0, 16'd200, 16'd100);
    write_reg(dlt_pkg::REG_DASH_SIZE, 32'hFFFF);
    send_segment(16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF);
    write_reg(dlt_pkg::REG_DASH_SIZE, 32'd0);
    send_segment(16'd0, 16'd0, 16'd500, 16'd500);
    write_reg(8'd7, 32'h1234_5678);
    write_reg(dlt_pkg::REG_LINE_COLOR, 32'd0);

    // Random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(dlt_pkg::REG_LINE_WIDTH,
                (ph == 0) ? 0 : $urandom_range(0, 65535) >> $urandom_range(0, 12));
      write_reg(dlt_pkg::REG_DASH_SIZE, $urandom_range(1, 400));
      write_reg(dlt_pkg::REG_LINE_COLOR, $urandom);
      sink_hold = (ph == 3);
      random_segments(19, (ph % 2) ? 8000 : 65535);
    end
    s_tvalid <= 0;

    while (board.pending.size() != 0) @(negedge clk);
    repeat (400) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("[dashed_line_tessellator] OK");
    else
      $display("[dashed_line_tessellator] ERROR");
    $finish;
  end
endmodule
